>>> rtl/core/sosmu_pkg.sv
// Shared definitions for the solid-on-solid Metropolis update block.
// Field widths, register indexes, field model codes, reset values and the
// decision struct. No dependencies.
`timescale 1ns / 1ps

package sosmu_pkg;

  // Default structural sizes
  localparam int SITES_DEF         = 64;
  localparam int MAX_DEVIATION_DEF = 127;

  // Fixed field widths
  localparam int DRAW_W     = 32;
  localparam int THR_W      = 33;
  localparam int HH_W       = 7;
  localparam int MODEL_W    = 2;
  localparam int MAG_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;
  localparam int THR_NUM    = 6;
  localparam int THR_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_MODEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_BASE    = 3'd2;

  // Field model codes (the unused code behaves as the absolute model)
  localparam logic [MODEL_W-1:0] MODEL_LINEAR  = 2'd0;
  localparam logic [MODEL_W-1:0] MODEL_ABS     = 2'd1;
  localparam logic [MODEL_W-1:0] MODEL_NEG_ABS = 2'd2;

  // Threshold table rows by SOS energy change
  localparam logic [1:0] ROW_SOS_MINUS = 2'd0;
  localparam logic [1:0] ROW_SOS_ZERO  = 2'd1;
  localparam logic [1:0] ROW_SOS_PLUS  = 2'd2;

  // Reset values
  localparam logic [HH_W-1:0]    HALF_HEIGHT_RST = 7'd30;
  localparam logic [MODEL_W-1:0] FIELD_MODEL_RST = MODEL_ABS;
  localparam logic [THR_W-1:0]   THR_RST_ONE     = 33'h1_0000_0000;
  localparam logic [THR_W-1:0]   THR_RST_PLUS    = 33'd501468825;

  // Outcome of one move evaluation
  typedef struct packed {
    logic accept;     // move applied
    logic field_pos;  // field term increment is +1
  } sosmu_decision_t;

endpackage

>>> rtl/core/sos_interface_metropolis_update.sv
// Metropolis update of a solid-on-solid interface on a ring of SITES columns.
// After reset the block runs a clearing pass that flattens
// every column to deviation zero; no move is taken during it, while
// configuration writes are taken at any time. Each move then runs as follows:
// the transaction is accepted and the column and its right neighbour are read
// from the two-port height memory, the left neighbour is read next, and the
// last step evaluates the move, writes back an accepted column and loads the
// result register. That step waits while an earlier result is still untaken.
// The next move is accepted in the cycle after. Thresholds are Q0.32 with
// 2^32 or more meaning always accept. Uses sosmu_pkg, sosmu_height_mem and
// sosmu_eval.
`timescale 1ns / 1ps

module sos_interface_metropolis_update
  import sosmu_pkg::*;
#(
  parameter int SITES         = SITES_DEF,
  parameter int MAX_DEVIATION = MAX_DEVIATION_DEF,
  parameter int SITE_W        = $clog2(SITES),
  parameter int DEV_W         = $clog2(MAX_DEVIATION + 1) + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // move proposals
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SITE_W-1:0]       in_site_index,
  input  logic                    in_step_up,
  input  logic [DRAW_W-1:0]       in_random_draw,
  // move results
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_accepted,
  output logic signed [DEV_W-1:0] out_new_deviation,
  output logic signed [MAG_W-1:0] out_magnetization_sum
);

  localparam logic [SITE_W:0]   SITES_E   = (SITE_W+1)'(SITES);
  localparam logic [SITE_W-1:0] LAST_SITE = SITE_W'(SITES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [HH_W-1:0]               half_height_r;
  logic [MODEL_W-1:0]            field_model_r;
  logic [THR_NUM-1:0][THR_W-1:0] thr_r;
  logic [THR_IDX_W-1:0]          cfg_thr_idx;

  // Move context
  logic [SITE_W-1:0]       site_in;
  logic [SITE_W-1:0]       site_p_in;
  logic [SITE_W-1:0]       site_m_in;
  logic [SITE_W-1:0]       site_r;
  logic [SITE_W-1:0]       site_m_r;
  logic                    step_up_r;
  logic [DRAW_W-1:0]       draw_r;
  logic signed [DEV_W-1:0] dev_c_r;
  logic signed [DEV_W-1:0] dev_p_r;
  logic [SITE_W-1:0]       clr_cnt_r;

  // Memory ports
  logic                mem_we;
  logic [SITE_W-1:0]   mem_waddr;
  logic [DEV_W-1:0]    mem_wdata;
  logic [SITE_W-1:0]   mem_ra_addr;
  logic [DEV_W-1:0]    mem_ra_data;
  logic [SITE_W-1:0]   mem_rb_addr;
  logic [DEV_W-1:0]    mem_rb_data;

  // Evaluation
  sosmu_decision_t         decision;
  logic signed [DEV_W-1:0] new_dev;
  logic                    in_fire;
  logic                    eval_fire;

  // Result register
  logic                    out_valid_r;
  logic                    out_accepted_r;
  logic signed [DEV_W-1:0] out_dev_r;
  logic signed [MAG_W-1:0] mag_r;

  // Configuration port is always ready
  assign cfg_ready   = 1'b1;
  assign cfg_thr_idx = THR_IDX_W'(cfg_index - REG_THR_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_height_r <= HALF_HEIGHT_RST;
      field_model_r <= FIELD_MODEL_RST;
      thr_r[0]      <= THR_RST_ONE;
      thr_r[1]      <= THR_RST_ONE;
      thr_r[2]      <= THR_RST_ONE;
      thr_r[3]      <= THR_RST_ONE;
      thr_r[4]      <= THR_RST_PLUS;
      thr_r[5]      <= THR_RST_PLUS;
    end else if (cfg_valid) begin
      priority if (cfg_index == REG_HALF_HEIGHT) begin
        half_height_r <= cfg_data[HH_W-1:0];
      end else if (cfg_index == REG_FIELD_MODEL) begin
        field_model_r <= cfg_data[MODEL_W-1:0];
      end else begin
        thr_r[cfg_thr_idx] <= cfg_data[THR_W-1:0];
      end
    end
  end

  // Site reduction onto the ring and neighbour addresses
  always_comb begin
    if ({1'b0, in_site_index} >= SITES_E) begin
      site_in = SITE_W'({1'b0, in_site_index} - SITES_E);
    end else begin
      site_in = in_site_index;
    end
    site_p_in = (site_in == LAST_SITE) ? '0 : site_in + SITE_W'(1);
    site_m_in = (site_in == '0) ? LAST_SITE : site_in - SITE_W'(1);
  end

  // Handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign eval_fire = (state_r == ST_EVAL) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_SITE) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (eval_fire) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + SITE_W'(1);
    end
  end

  // Move context capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      site_r    <= site_in;
      site_m_r  <= site_m_in;
      step_up_r <= in_step_up;
      draw_r    <= in_random_draw;
    end
    if (state_r == ST_READ) begin
      dev_c_r <= signed'(mem_ra_data);
      dev_p_r <= signed'(mem_rb_data);
    end
  end

  // Memory port steering: clearing pass or write-back
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = site_r;
    mem_wdata   = new_dev;
    mem_ra_addr = site_r;
    mem_rb_addr = site_m_r;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (eval_fire && decision.accept) begin
      mem_we = 1'b1;
    end
    if (state_r == ST_IDLE) begin
      mem_ra_addr = site_in;
      mem_rb_addr = site_p_in;
    end
  end

  sosmu_height_mem #(
    .DEPTH (SITES),
    .AW    (SITE_W),
    .DW    (DEV_W)
  ) u_height_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .ra_addr (mem_ra_addr),
    .ra_data (mem_ra_data),
    .rb_addr (mem_rb_addr),
    .rb_data (mem_rb_data)
  );

  // Left neighbour arrives on port B during evaluation
  sosmu_eval #(
    .MAX_DEVIATION (MAX_DEVIATION),
    .DEV_W         (DEV_W)
  ) u_eval (
    .half_height (half_height_r),
    .field_model (field_model_r),
    .thr         (thr_r),
    .step_up     (step_up_r),
    .draw        (draw_r),
    .dev_c       (dev_c_r),
    .dev_p       (dev_p_r),
    .dev_m       (signed'(mem_rb_data)),
    .decision    (decision),
    .new_dev     (new_dev)
  );

  // Magnetization accumulator, wraps in its width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
    end else if (eval_fire && decision.accept) begin
      mag_r <= decision.field_pos ? mag_r + MAG_W'(1) : mag_r - MAG_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eval_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      out_accepted_r <= decision.accept;
      out_dev_r      <= new_dev;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_accepted          = out_accepted_r;
  assign out_new_deviation     = out_dev_r;
  assign out_magnetization_sum = mag_r;

endmodule

>>> rtl/core/sosmu_height_mem.sv
// Height deviation store: one write port, two registered read ports.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module sosmu_height_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] ra_addr,
  output logic [DW-1:0] ra_data,
  input  logic [AW-1:0] rb_addr,
  output logic [DW-1:0] rb_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

>>> rtl/core/sosmu_eval.sv
// Move evaluation: SOS energy change, field term sign, threshold pick,
// bound check and new deviation. Uses sosmu_pkg.
`timescale 1ns / 1ps

module sosmu_eval
  import sosmu_pkg::*;
#(
  parameter int MAX_DEVIATION = MAX_DEVIATION_DEF,
  parameter int DEV_W         = 8
) (
  input  logic [HH_W-1:0]                  half_height,
  input  logic [MODEL_W-1:0]               field_model,
  input  logic [THR_NUM-1:0][THR_W-1:0]    thr,
  input  logic                             step_up,
  input  logic [DRAW_W-1:0]                draw,
  input  logic signed [DEV_W-1:0]          dev_c,
  input  logic signed [DEV_W-1:0]          dev_p,
  input  logic signed [DEV_W-1:0]          dev_m,
  output sosmu_decision_t                  decision,
  output logic signed [DEV_W-1:0]          new_dev
);

  // Compare width holds the limit, the capped centre and the stepped height
  localparam int CW = ((DEV_W > HH_W + 1) ? DEV_W : HH_W + 1) + 1;
  localparam logic signed [CW-1:0] MAX_DEV_C = CW'(MAX_DEVIATION);

  logic signed [CW-1:0]  dev_e;
  logic signed [CW-1:0]  dev2;
  logic signed [CW-1:0]  hh_e;
  logic signed [CW-1:0]  lim;
  logic                  inc_m;
  logic                  inc_p;
  logic [1:0]            row;
  logic                  grows;
  logic                  field_pos;
  logic [THR_IDX_W-1:0]  thr_idx;
  logic [THR_W-1:0]      thr_sel;
  logic                  in_range;
  logic                  accept;

  // Stepped height and capped centre
  assign dev_e = signed'({{(CW-DEV_W){dev_c[DEV_W-1]}}, dev_c});
  assign dev2  = step_up ? dev_e + CW'(1) : dev_e - CW'(1);
  assign hh_e  = signed'({{(CW-HH_W){1'b0}}, half_height});
  assign lim   = (hh_e > MAX_DEV_C) ? MAX_DEV_C : hh_e;

  // Each neighbour bond changes by +1 or -1
  assign inc_m = step_up ? (dev_c >= dev_m) : (dev_c <= dev_m);
  assign inc_p = step_up ? (dev_c >= dev_p) : (dev_c <= dev_p);

  always_comb begin
    priority if (inc_m && inc_p) begin
      row = ROW_SOS_PLUS;
    end else if (!inc_m && !inc_p) begin
      row = ROW_SOS_MINUS;
    end else begin
      row = ROW_SOS_ZERO;
    end
  end

  // Field term sign: |d| grows when stepping away from zero
  assign grows = step_up ? (dev_c >= 0) : (dev_c <= 0);

  always_comb begin
    priority if (field_model == MODEL_LINEAR) begin
      field_pos = !step_up;
    end else if (field_model == MODEL_NEG_ABS) begin
      field_pos = !grows;
    end else begin
      field_pos = grows;
    end
  end

  // Threshold pick and acceptance
  assign thr_idx  = {row, field_pos};
  assign thr_sel  = thr[thr_idx];
  assign in_range = (dev2 >= -lim) && (dev2 <= lim);
  assign accept   = in_range && ({1'b0, draw} < thr_sel);

  assign decision.accept    = accept;
  assign decision.field_pos = field_pos;
  assign new_dev            = accept ? dev2[DEV_W-1:0] : dev_c;

endmodule
